// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is high.
`define SPF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is also checked while reset is high.
`define SPF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/spf_pkg.sv
// ----------------------------------------------------------------------------
// spf_pkg
// Types and codes of the peer-session state machine.
// ----------------------------------------------------------------------------
package spf_pkg;

   localparam int EV_W    = 4;
   localparam int ST_W    = 3;
   localparam int CMD_W   = 2;
   localparam int LOAD_W  = 26;
   localparam int SEC_W   = 16;
   localparam int VER_W   = 8;
   localparam int CODE_W  = 2;
   localparam int ADDR_W  = 2;
   localparam int REQ_DW  = 16;
   localparam int RSP_DW  = 104;

   localparam logic [LOAD_W-1:0] MS_PER_SEC = LOAD_W'(1000);

   // Register indexes
   localparam logic [ADDR_W-1:0] REG_RETRY     = 2'd0;
   localparam logic [ADDR_W-1:0] REG_KEEPALIVE = 2'd1;
   localparam logic [ADDR_W-1:0] REG_HOLD      = 2'd2;
   localparam logic [ADDR_W-1:0] REG_VERSION   = 2'd3;

   localparam logic [LOAD_W-1:0] RETRY_LOAD_RST     = LOAD_W'(30) * MS_PER_SEC;
   localparam logic [LOAD_W-1:0] KEEPALIVE_LOAD_RST = LOAD_W'(30) * MS_PER_SEC;
   localparam logic [LOAD_W-1:0] HOLD_LOAD_RST      = LOAD_W'(90) * MS_PER_SEC;
   localparam logic [VER_W-1:0]  VERSION_RST        = 8'd1;

   // Session states
   localparam logic [ST_W-1:0] PS_IDLE         = 3'd0;
   localparam logic [ST_W-1:0] PS_CONNECT      = 3'd1;
   localparam logic [ST_W-1:0] PS_ACTIVE       = 3'd2;
   localparam logic [ST_W-1:0] PS_OPEN_SENT    = 3'd3;
   localparam logic [ST_W-1:0] PS_OPEN_CONFIRM = 3'd4;
   localparam logic [ST_W-1:0] PS_ESTABLISHED  = 3'd5;

   // Events
   localparam logic [EV_W-1:0] EV_START         = 4'd0;
   localparam logic [EV_W-1:0] EV_STOP          = 4'd1;
   localparam logic [EV_W-1:0] EV_CONN_OPEN     = 4'd2;
   localparam logic [EV_W-1:0] EV_OPEN_FAILED   = 4'd3;
   localparam logic [EV_W-1:0] EV_CLOSED        = 4'd4;
   localparam logic [EV_W-1:0] EV_TRANSPORT_ERR = 4'd5;
   localparam logic [EV_W-1:0] EV_RETRY_EXP     = 4'd6;
   localparam logic [EV_W-1:0] EV_KA_EXP        = 4'd7;
   localparam logic [EV_W-1:0] EV_RX_OPEN       = 4'd8;
   localparam logic [EV_W-1:0] EV_RX_KA         = 4'd9;
   localparam logic [EV_W-1:0] EV_RX_UPDATE     = 4'd10;
   localparam logic [EV_W-1:0] EV_RX_NOTIFY     = 4'd11;

   // Transport commands
   localparam logic [CMD_W-1:0] TC_NONE       = 2'd0;
   localparam logic [CMD_W-1:0] TC_OPEN       = 2'd1;
   localparam logic [CMD_W-1:0] TC_RESET      = 2'd2;
   localparam logic [CMD_W-1:0] TC_RESET_OPEN = 2'd3;

   // Timer commands
   localparam logic [CMD_W-1:0] TM_NONE    = 2'd0;
   localparam logic [CMD_W-1:0] TM_START   = 2'd1;
   localparam logic [CMD_W-1:0] TM_RESTART = 2'd2;
   localparam logic [CMD_W-1:0] TM_CLEAR   = 2'd3;

   // Message kinds
   localparam logic [CMD_W-1:0] SK_NONE      = 2'd0;
   localparam logic [CMD_W-1:0] SK_OPEN      = 2'd1;
   localparam logic [CMD_W-1:0] SK_KEEPALIVE = 2'd2;
   localparam logic [CMD_W-1:0] SK_NOTIFY    = 2'd3;

   // Notification codes
   localparam logic [CODE_W-1:0] NC_CEASE    = 2'd0;
   localparam logic [CODE_W-1:0] NC_OPEN_ERR = 2'd1;
   localparam logic [CODE_W-1:0] NC_FSM_ERR  = 2'd2;

   typedef struct packed {
      logic [VER_W-1:0] peer_version;
      logic             msg_present;
      logic [EV_W-1:0]  event_req;
   } spf_req_type;

   typedef struct packed {
      logic [LOAD_W-1:0] retry_load_ms;
      logic [LOAD_W-1:0] keepalive_load_ms;
      logic [LOAD_W-1:0] hold_load_ms;
      logic [VER_W-1:0]  supported_version;
   } spf_cfg_type;

   typedef struct packed {
      logic [ST_W-1:0]   new_state;
      logic [CMD_W-1:0]  transport_cmd;
      logic [CMD_W-1:0]  retry_timer_cmd;
      logic [CMD_W-1:0]  keepalive_timer_cmd;
      logic [CMD_W-1:0]  hold_timer_cmd;
      logic [LOAD_W-1:0] retry_load_ms;
      logic [LOAD_W-1:0] keepalive_load_ms;
      logic [LOAD_W-1:0] hold_load_ms;
      logic [CMD_W-1:0]  send_kind;
      logic [CODE_W-1:0] notify_code;
      logic              notify_subcode;
      logic [VER_W-1:0]  notify_data;
   } spf_rsp_type;

endpackage

// File: src/spf_csr.sv
// ----------------------------------------------------------------------------
// spf_csr
// Configuration registers; timer durations are kept already scaled to ms.
// ----------------------------------------------------------------------------
module spf_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [spf_pkg::ADDR_W-1:0]  csr_addr,
   input  logic [spf_pkg::SEC_W-1:0]   csr_wdata,
   output spf_pkg::spf_cfg_type        cfg
);
   import spf_pkg::*;

   spf_cfg_type       cfg_ff;
   spf_cfg_type       cfg_in;
   logic [LOAD_W-1:0] wdata_ms;

   // Seconds to milliseconds once, at write time.
   assign wdata_ms = LOAD_W'(csr_wdata) * MS_PER_SEC;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_RETRY:     cfg_in.retry_load_ms     = wdata_ms;
            REG_KEEPALIVE: cfg_in.keepalive_load_ms = wdata_ms;
            REG_HOLD:      cfg_in.hold_load_ms      = wdata_ms;
            REG_VERSION:   cfg_in.supported_version = csr_wdata[VER_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.retry_load_ms     <= RETRY_LOAD_RST;
         cfg_ff.keepalive_load_ms <= KEEPALIVE_LOAD_RST;
         cfg_ff.hold_load_ms      <= HOLD_LOAD_RST;
         cfg_ff.supported_version <= VERSION_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: src/spf_decode.sv
// ----------------------------------------------------------------------------
// spf_decode
// Decodes the current state and one event into next state and commands.
// ----------------------------------------------------------------------------
module spf_decode (
   input  logic [spf_pkg::ST_W-1:0] cur_state,
   input  spf_pkg::spf_req_type     req,
   input  spf_pkg::spf_cfg_type     cfg,
   output spf_pkg::spf_rsp_type     rsp
);
   import spf_pkg::*;

   logic [ST_W-1:0]   cur;
   logic [ST_W-1:0]   st;
   logic [CMD_W-1:0]  tc;
   logic [CMD_W-1:0]  rt;
   logic [CMD_W-1:0]  kt;
   logic [CMD_W-1:0]  ht;
   logic [CMD_W-1:0]  sk;
   logic [CODE_W-1:0] code;
   logic              sub;
   logic [VER_W-1:0]  data;
   logic              release_all;
   logic              notify;

   always_comb begin
      cur = (cur_state > PS_ESTABLISHED) ? PS_IDLE : cur_state;
      st = cur;
      tc = TC_NONE;
      rt = TM_NONE;
      kt = TM_NONE;
      ht = TM_NONE;
      sk = SK_NONE;
      code = NC_CEASE;
      sub = 1'b0;
      data = '0;
      release_all = 1'b0;
      notify = 1'b0;

      if (cur == PS_IDLE) begin
         if (req.event_req == EV_START) begin
            tc = TC_OPEN;
            rt = TM_START;
            st = PS_CONNECT;
         end else if (req.event_req == EV_TRANSPORT_ERR) begin
            release_all = 1'b1;
         end
      end else if (req.event_req == EV_START) begin
         // Start is ignored once the session is running.
      end else if (req.event_req == EV_TRANSPORT_ERR) begin
         release_all = 1'b1;
      end else if (cur == PS_CONNECT || cur == PS_ACTIVE) begin
         case (req.event_req)
            EV_CONN_OPEN: begin
               rt = TM_CLEAR;
               sk = SK_OPEN;
               kt = TM_START;
               ht = TM_START;
               st = PS_OPEN_SENT;
            end
            EV_OPEN_FAILED: begin
               tc = TC_RESET;
               rt = TM_RESTART;
               st = PS_ACTIVE;
            end
            EV_RETRY_EXP: begin
               tc = TC_RESET_OPEN;
               rt = TM_RESTART;
               st = PS_CONNECT;
            end
            default: notify = 1'b1;
         endcase
      end else if (cur == PS_OPEN_SENT) begin
         if (req.event_req == EV_CLOSED) begin
            tc = TC_RESET;
            rt = TM_RESTART;
            st = PS_ACTIVE;
         end else if (req.event_req == EV_RX_OPEN) begin
            if (!req.msg_present) begin
               notify = 1'b1;
            end else if (req.peer_version > cfg.supported_version) begin
               notify = 1'b1;
               code = NC_OPEN_ERR;
               sub = 1'b1;
               data = cfg.supported_version;
            end else begin
               sk = SK_KEEPALIVE;
               st = PS_OPEN_CONFIRM;
            end
         end else begin
            notify = 1'b1;
         end
      end else begin
         // OpenConfirm and Established share most of their handling.
         case (req.event_req)
            EV_CLOSED, EV_RX_NOTIFY: release_all = 1'b1;
            EV_KA_EXP: begin
               sk = SK_KEEPALIVE;
               kt = TM_RESTART;
            end
            EV_RX_KA: begin
               ht = TM_RESTART;
               st = PS_ESTABLISHED;
            end
            EV_RX_UPDATE: begin
               if (cur == PS_OPEN_CONFIRM) begin
                  notify = 1'b1;
               end else if (!req.msg_present) begin
                  release_all = 1'b1;
               end
            end
            EV_STOP: notify = 1'b1;
            default: begin
               notify = 1'b1;
               if (cur == PS_ESTABLISHED) begin
                  code = NC_FSM_ERR;
               end
            end
         endcase
      end

      if (notify) begin
         sk = SK_NOTIFY;
         release_all = 1'b1;
      end
      if (release_all) begin
         tc = TC_RESET;
         rt = TM_CLEAR;
         kt = TM_CLEAR;
         ht = TM_CLEAR;
         st = PS_IDLE;
      end
   end

   always_comb begin
      rsp.new_state           = st;
      rsp.transport_cmd       = tc;
      rsp.retry_timer_cmd     = rt;
      rsp.keepalive_timer_cmd = kt;
      rsp.hold_timer_cmd      = ht;
      rsp.retry_load_ms       = (rt == TM_START || rt == TM_RESTART) ?
                                cfg.retry_load_ms : '0;
      rsp.keepalive_load_ms   = (kt == TM_START || kt == TM_RESTART) ?
                                cfg.keepalive_load_ms : '0;
      rsp.hold_load_ms        = (ht == TM_START || ht == TM_RESTART) ?
                                cfg.hold_load_ms : '0;
      rsp.send_kind           = sk;
      rsp.notify_code         = (sk == SK_NOTIFY) ? code : NC_CEASE;
      rsp.notify_subcode      = (sk == SK_NOTIFY) ? sub : 1'b0;
      rsp.notify_data         = (sk == SK_NOTIFY) ? data : '0;
   end

endmodule

// File: src/session_peer_fsm.sv
// ----------------------------------------------------------------------------
// session_peer_fsm
// Six-state peer-session machine turning events into transport, timer and
// message commands.
// ----------------------------------------------------------------------------
// Usage:
// Each request on the req_ stream carries one event, the message-present
// flag and the peer version byte. Every request yields exactly one response
// on the rsp_ stream with the next state, the transport command, the three
// timer commands with their millisecond loads and the message to send.
// An accepted request is held in the input register, and its response is
// captured in the result register, which drives rsp_tvalid and rsp_tdata.
// Throughput is one request per cycle while the receiver does not stall;
// the session state is updated as a request moves to the result register,
// so the next request sees it at once. When the receiver stalls, the result
// register holds its response and the input register can still take one
// more request; req_tready drops only when both are full. Reset clears both
// valid flags, returns the session to Idle and reloads the configuration
// defaults (30 s retry, 30 s keepalive, 90 s hold, version 1). csr_ writes
// take effect on the next cycle and must be made only while the block is
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module session_peer_fsm (
   input  logic                        clock,
   input  logic                        reset,
   // event_req[3:0], msg_present[4], peer_version[12:5], zero pad[15:13]
   input  logic [spf_pkg::REQ_DW-1:0]  req_tdata,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // new_state[2:0], transport_cmd[4:3], retry_timer_cmd[6:5],
   // keepalive_timer_cmd[8:7], hold_timer_cmd[10:9], retry_load_ms[36:11],
   // keepalive_load_ms[62:37], hold_load_ms[88:63], send_kind[90:89],
   // notify_code[92:91], notify_subcode[93], notify_data[101:94],
   // zero pad[103:102]
   output logic [spf_pkg::RSP_DW-1:0]  rsp_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic                        csr_we,
   input  logic [spf_pkg::ADDR_W-1:0]  csr_addr,
   input  logic [spf_pkg::SEC_W-1:0]   csr_wdata
);
   import spf_pkg::*;

   spf_cfg_type     cfg;
   spf_req_type     req_ff;
   logic            req_valid_ff;
   logic [ST_W-1:0] state_ff;
   spf_rsp_type     dec_rsp;
   spf_rsp_type     rsp_ff;
   logic            rsp_valid_ff;
   logic            advance;

   spf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   spf_decode u_decode (
      .cur_state (state_ff),
      .req       (req_ff),
      .cfg       (cfg),
      .rsp       (dec_rsp)
   );

   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= PS_IDLE;
      end else begin
         if (req_tready) begin
            req_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= dec_rsp.new_state;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_ff.event_req    <= req_tdata[3:0];
         req_ff.msg_present  <= req_tdata[4];
         req_ff.peer_version <= req_tdata[12:5];
      end
      if (advance) begin
         rsp_ff <= dec_rsp;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00,
                        rsp_ff.notify_data,
                        rsp_ff.notify_subcode,
                        rsp_ff.notify_code,
                        rsp_ff.send_kind,
                        rsp_ff.hold_load_ms,
                        rsp_ff.keepalive_load_ms,
                        rsp_ff.retry_load_ms,
                        rsp_ff.hold_timer_cmd,
                        rsp_ff.keepalive_timer_cmd,
                        rsp_ff.retry_timer_cmd,
                        rsp_ff.transport_cmd,
                        rsp_ff.new_state};

endmodule

// File: src/spf_checker.sv
// ----------------------------------------------------------------------------
// spf_checker
// Port-level checks of the session machine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spf_checker (
   input logic                        clock,
   input logic                        reset,
   input logic [spf_pkg::RSP_DW-1:0]  rsp_tdata,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready
);
   import spf_pkg::*;

   logic [ST_W-1:0]         rsp_state;
   logic [CMD_W-1:0]        rsp_kind;
   logic [CODE_W+VER_W:0]   rsp_notify;
   logic [CMD_W-1:0]        rsp_retry_cmd;
   logic [LOAD_W-1:0]       rsp_retry_load;
   logic                    stalled;

   assign rsp_state      = rsp_tdata[2:0];
   assign rsp_kind       = rsp_tdata[90:89];
   assign rsp_notify     = rsp_tdata[101:91];
   assign rsp_retry_cmd  = rsp_tdata[6:5];
   assign rsp_retry_load = rsp_tdata[36:11];
   assign stalled        = rsp_tvalid && !rsp_tready;

   property p_hold_stall;
      stalled |=> rsp_tvalid && $stable(rsp_tdata);
   endproperty

   property p_state_range;
      rsp_tvalid |-> rsp_state <= PS_ESTABLISHED;
   endproperty

   property p_notify_zero;
      rsp_tvalid && rsp_kind != SK_NOTIFY |-> rsp_notify == '0;
   endproperty

   property p_retry_load;
      rsp_tvalid && (rsp_retry_cmd == TM_NONE || rsp_retry_cmd == TM_CLEAR)
         |-> rsp_retry_load == '0;
   endproperty

   `SPF_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_tvalid, "response valid after reset")
   `SPF_ASSERT(a_hold_stall, clock, reset, p_hold_stall, "stalled response changed")
   `SPF_ASSERT(a_state_range, clock, reset, p_state_range, "next state out of range")
   `SPF_ASSERT(a_notify_zero, clock, reset, p_notify_zero, "notification fields set")
   `SPF_ASSERT(a_retry_load, clock, reset, p_retry_load, "retry load without start")

endmodule

bind session_peer_fsm spf_checker u_spf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
